@@ hdl/itr_pkg.sv @@
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, constants and the digit character map for the
// integer-to-radix-digits converter.
// ----------------------------------------------------------------------------
package itr_pkg;

    localparam int NUMBER_BITS_DEFAULT = 64;
    localparam int NUMBER_W            = 64;
    localparam int RADIX_W             = 6;
    localparam int DIGIT_W             = 6;
    localparam int CHAR_W              = 7;
    localparam int STORE_DEPTH         = 64;
    localparam int STORE_AW            = 6;
    localparam int COUNT_W             = 7;
    localparam int CHUNK_BITS          = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd97;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_READ,
        ST_EMIT
    } itr_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd;
        logic emit;
    } itr_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic div_last;
        logic quot_zero;
        logic count_full;
        logic count_one;
    } itr_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < 6'd10)
            return CHAR_ZERO + dx;
        else if (d < RADIX_MAX)
            return CHAR_A + dx - 7'd10;
        else
            return CHAR_ZERO;
    endfunction

endpackage

@@ hdl/itr_ram.sv @@
// ----------------------------------------------------------------------------
// itr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module itr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/itr_datapath.sv @@
// ----------------------------------------------------------------------------
// itr_datapath
// Radix register, chunked long divider, digit store and character output.
// ----------------------------------------------------------------------------
module itr_datapath #(
    parameter int NUMBER_BITS = itr_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itr_pkg::itr_cmd_t                   cmd,
    output itr_pkg::itr_stat_t                  stat,
    input  logic [itr_pkg::NUMBER_W-1:0]        number,
    input  logic                                cfg_valid,
    input  logic [itr_pkg::RADIX_W-1:0]         cfg_radix,
    output logic [itr_pkg::CHAR_W-1:0]          digit_char,
    output logic                                last_char
);

    localparam int CHUNKS   = (NUMBER_BITS + itr_pkg::CHUNK_BITS - 1) / itr_pkg::CHUNK_BITS;
    localparam int PAD_BITS = CHUNKS * itr_pkg::CHUNK_BITS;
    localparam int STEP_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHUNKS - 1);

    logic [itr_pkg::RADIX_W-1:0]  radix_reg;
    logic [PAD_BITS-1:0]          quot_reg, quot_next;
    logic [itr_pkg::DIGIT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]            step_reg;
    logic [itr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [itr_pkg::COUNT_W-1:0]  count_dec;
    logic [itr_pkg::DIGIT_W-1:0]  rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itr_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= cfg_radix;
        end
    end

    // one chunk of restoring long division per cycle, remainder stays below radix
    always_comb
    begin
        logic [itr_pkg::DIGIT_W:0]          t;
        logic [itr_pkg::DIGIT_W-1:0]        r;
        logic [itr_pkg::CHUNK_BITS-1:0]     qb;
        r  = rem_reg;
        qb = '0;
        for (int i = 0; i < itr_pkg::CHUNK_BITS; i++)
        begin
            t = {r, quot_reg[PAD_BITS-1-i]};
            if (t >= {1'b0, radix_reg})
            begin
                r = itr_pkg::DIGIT_W'(t - {1'b0, radix_reg});
                qb[itr_pkg::CHUNK_BITS-1-i] = 1'b1;
            end
            else
            begin
                r = t[itr_pkg::DIGIT_W-1:0];
            end
        end
        quot_next = (quot_reg << itr_pkg::CHUNK_BITS) | PAD_BITS'(qb);
        rem_next  = r;
    end

    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
            count_next = '0;
        else if (cmd.store)
            count_next = count_reg + 1'b1;
        else if (cmd.emit)
            count_next = count_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load || cmd.store)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= PAD_BITS'(number[NUMBER_BITS-1:0]);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
        end
    end

    itr_ram #(
        .WIDTH (itr_pkg::DIGIT_W),
        .DEPTH (itr_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (count_reg[itr_pkg::STORE_AW-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd),
        .rd_addr (count_dec[itr_pkg::STORE_AW-1:0]),
        .rd_data (rd_data)
    );

    assign stat.radix_ok   = (radix_reg >= itr_pkg::RADIX_MIN) && (radix_reg <= itr_pkg::RADIX_MAX);
    assign stat.div_last   = (step_reg == STEP_LAST);
    assign stat.quot_zero  = (quot_reg == '0);
    assign stat.count_full = (count_reg == itr_pkg::COUNT_W'(itr_pkg::STORE_DEPTH - 1));
    assign stat.count_one  = (count_reg == itr_pkg::COUNT_W'(1));

    assign digit_char = itr_pkg::digit_to_ascii(rd_data);
    assign last_char  = cmd.emit && stat.count_one;

endmodule

@@ hdl/itr_ctrl.sv @@
// ----------------------------------------------------------------------------
// itr_ctrl
// Sequencer: division passes per digit, then read-out of the digit store.
// ----------------------------------------------------------------------------
module itr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  itr_pkg::itr_stat_t stat,
    output itr_pkg::itr_cmd_t  cmd,
    output logic               busy
);

    itr_pkg::itr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            itr_pkg::ST_IDLE:
            begin
                // bad radix: the item is taken and yields nothing
                if (start && stat.radix_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = itr_pkg::ST_DIV;
                end
            end
            itr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = itr_pkg::ST_STORE;
            end
            itr_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                if (stat.quot_zero || stat.count_full)
                    state_next = itr_pkg::ST_READ;
                else
                    state_next = itr_pkg::ST_DIV;
            end
            itr_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = itr_pkg::ST_EMIT;
            end
            itr_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.count_one)
                    state_next = itr_pkg::ST_IDLE;
                else
                    state_next = itr_pkg::ST_READ;
            end
            default:
            begin
                state_next = itr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != itr_pkg::ST_IDLE);

endmodule

@@ hdl/integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned integer to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   Write the base on cfg_radix with cfg_valid (cfg_ready is always high);
//   reset sets base 16. Write it only while busy is low.
//   An item is taken when start is high and busy is low. The low NUMBER_BITS
//   bits of number are converted; busy stays high until the last character.
//   Characters come most significant first, one per out_valid pulse, with
//   last_char set on the final one. Zero gives the single character '0'.
//   A base outside 2..36 gives no characters and busy never rises.
// Sequence:
//   Each digit is formed by the divider, which retires 8 dividend bits per
//   cycle, and is then written to the digit store. Each character is read
//   from the digit store (registered RAM read) and then emitted.
//   The receiver cannot stall; every out_valid pulse is one character.
//   Reset returns the block to idle; the digit store needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int NUMBER_BITS = itr_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [itr_pkg::NUMBER_W-1:0]  number,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [itr_pkg::RADIX_W-1:0]   cfg_radix,
    output logic                          out_valid,
    output logic [itr_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last_char
);

    itr_pkg::itr_cmd_t  cmd;
    itr_pkg::itr_stat_t stat;

    assign cfg_ready = 1'b1;
    assign out_valid = cmd.emit;

    itr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    itr_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .number     (number),
        .cfg_valid  (cfg_valid),
        .cfg_radix  (cfg_radix),
        .digit_char (digit_char),
        .last_char  (last_char)
    );

endmodule
